### rtl/svalloc_pkg.sv
`timescale 1ns / 1ps
// Shared definitions for the sound-effect voice allocator.
// Operation, action and register codes, parameter defaults, and the
// command and status bundles between controller and datapath.
package svalloc_pkg;

  localparam int unsigned DefMaxSamples  = 64;
  localparam int unsigned DefMaxChannels = 8;
  localparam int unsigned DefIdWidth     = 16;

  localparam logic [1:0] OpRegister = 2'd0;
  localparam logic [1:0] OpPlay     = 2'd1;
  localparam logic [1:0] OpStop     = 2'd2;
  localparam logic [1:0] OpStopAll  = 2'd3;

  localparam logic [1:0] ActNone  = 2'd0;
  localparam logic [1:0] ActStart = 2'd1;
  localparam logic [1:0] ActStop  = 2'd2;

  localparam logic CfgFirstChannel = 1'b0;
  localparam logic CfgChannelCount = 1'b1;

  typedef struct packed {
    logic accept;
    logic fire;
  } cmd_t;

  typedef struct packed {
    logic final_res;
  } status_t;

endpackage

### rtl/svalloc_ctrl.sv
`timescale 1ns / 1ps
// Controller for the sound-effect voice allocator.
// Sequences request acceptance, result generation and the output register.
// Depends on svalloc_pkg for the command and status bundles.
module svalloc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  svalloc_pkg::status_t status_i,
  output svalloc_pkg::cmd_t    cmd_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q && out_stall_i;
    cmd_o.accept = 1'b0;
    cmd_o.fire   = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = StExec;
        end
      end
      StExec: begin
        if (out_free) begin
          cmd_o.fire  = 1'b1;
          out_valid_d = 1'b1;
          if (status_i.final_res) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

  a_fire_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fire |-> (!out_valid_q || !out_stall_i))
    else $error("result generated while output register is occupied");

  a_accept_then_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> (state_q == StExec))
    else $error("accepted request did not start execution");

  a_final_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.fire && status_i.final_res) |=> (state_q == StIdle && out_valid_q))
    else $error("final result did not return the controller to idle");

  a_fire_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fire |=> out_valid_q)
    else $error("generated result not presented at the output");

endmodule

### rtl/svalloc_datapath.sv
`timescale 1ns / 1ps
// Datapath for the sound-effect voice allocator.
// Holds configuration, channel records, counters, the request latch and the
// output register. Depends on svalloc_pkg for codes and command bundles.
module svalloc_datapath #(
  parameter int unsigned MaxSamples  = svalloc_pkg::DefMaxSamples,
  parameter int unsigned MaxChannels = svalloc_pkg::DefMaxChannels,
  parameter int unsigned IdWidth     = svalloc_pkg::DefIdWidth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [4:0]           cfg_data_i,
  input  logic [1:0]           operation_i,
  input  logic [5:0]           sample_index_i,
  input  logic [6:0]           volume_i,
  input  logic [16:0]          rate_i,
  input  logic signed [7:0]    panning_i,
  input  logic [15:0]          play_id_i,
  input  logic [7:0]           playing_mask_i,
  input  svalloc_pkg::cmd_t    cmd_i,
  output svalloc_pkg::status_t status_o,
  output logic                 status_bit_o,
  output logic [15:0]          result_value_o,
  output logic [1:0]           action_o,
  output logic [5:0]           channel_o,
  output logic [5:0]           out_sample_o,
  output logic [6:0]           out_volume_o,
  output logic [16:0]          out_rate_o,
  output logic signed [7:0]    out_panning_o,
  output logic                 last_o
);

  localparam int unsigned ChLimit = (MaxChannels < 8) ? MaxChannels : 8;
  localparam int unsigned ChIdxW  = (ChLimit > 1) ? $clog2(ChLimit) : 1;
  localparam int unsigned ScW     = $clog2(MaxSamples + 1);
  localparam int unsigned SmpCmpW = (ScW > 6) ? ScW : 6;
  localparam int unsigned IdKeepW = (IdWidth < 16) ? IdWidth : 16;

  logic [4:0]          first_channel_q;
  logic [3:0]          channel_count_q;
  logic [ScW-1:0]      sample_count_q;
  logic [ChLimit-1:0]  chan_valid_q;
  logic [5:0]          chan_sample_q [ChLimit];
  logic [IdKeepW-1:0]  chan_id_q [ChLimit];
  logic [ChIdxW-1:0]   last_used_q;
  logic [IdWidth-1:0]  id_counter_q;
  logic [ChIdxW-1:0]   idx_q;

  logic [1:0]          op_q;
  logic [5:0]          smp_q;
  logic [6:0]          vol_q;
  logic [16:0]         rate_q;
  logic signed [7:0]   pan_q;
  logic [15:0]         pid_q;
  logic [7:0]          mask_q;

  logic [3:0]          win_n;
  logic                idle_hit, same_hit, stop_hit;
  logic [ChIdxW-1:0]   idle_ch, same_ch, stop_ch, rr_ch, play_ch;
  logic [3:0]          lu_plus;
  logic                smp_bad, full;
  logic [IdWidth-1:0]  id_next;
  logic                idx_last;

  logic                res_status;
  logic [15:0]         res_value;
  logic [1:0]          res_action;
  logic [5:0]          res_channel;
  logic [5:0]          res_sample;
  logic [6:0]          res_volume;
  logic [16:0]         res_rate;
  logic signed [7:0]   res_panning;
  logic                res_last;
  logic                do_play;

  always_comb begin
    if (channel_count_q == 4'd0) begin
      win_n = 4'd1;
    end else if (channel_count_q > 4'(ChLimit)) begin
      win_n = 4'(ChLimit);
    end else begin
      win_n = channel_count_q;
    end
  end

  always_comb begin
    idle_hit = 1'b0;
    same_hit = 1'b0;
    stop_hit = 1'b0;
    idle_ch  = '0;
    same_ch  = '0;
    stop_ch  = '0;
    for (int i = ChLimit - 1; i >= 0; i--) begin
      if (4'(i) < win_n) begin
        if (!mask_q[i]) begin
          idle_hit = 1'b1;
          idle_ch  = ChIdxW'(i);
        end
        if (chan_valid_q[i] && chan_sample_q[i] == smp_q) begin
          same_hit = 1'b1;
          same_ch  = ChIdxW'(i);
        end
        if (chan_valid_q[i] && 16'(chan_id_q[i]) == pid_q) begin
          stop_hit = 1'b1;
          stop_ch  = ChIdxW'(i);
        end
      end
    end
  end

  assign lu_plus  = 4'(last_used_q) + 4'd1;
  assign rr_ch    = (lu_plus >= win_n) ? '0 : lu_plus[ChIdxW-1:0];
  assign play_ch  = idle_hit ? idle_ch : (same_hit ? same_ch : rr_ch);
  assign smp_bad  = SmpCmpW'(smp_q) >= SmpCmpW'(sample_count_q);
  assign full     = (sample_count_q == ScW'(MaxSamples));
  assign id_next  = id_counter_q + 1'b1;
  assign idx_last = ((4'(idx_q) + 4'd1) == win_n);

  assign status_o.final_res = (op_q != svalloc_pkg::OpStopAll) || idx_last;

  always_comb begin
    res_status  = 1'b0;
    res_value   = '0;
    res_action  = svalloc_pkg::ActNone;
    res_channel = '0;
    res_sample  = '0;
    res_volume  = '0;
    res_rate    = '0;
    res_panning = '0;
    res_last    = 1'b1;
    do_play     = 1'b0;
    unique case (op_q)
      svalloc_pkg::OpRegister: begin
        if (full) begin
          res_status = 1'b1;
        end else begin
          res_value = 16'(sample_count_q);
        end
      end
      svalloc_pkg::OpPlay: begin
        if (smp_bad) begin
          res_status = 1'b1;
        end else begin
          do_play     = 1'b1;
          res_value   = 16'(id_next[IdKeepW-1:0]);
          res_action  = svalloc_pkg::ActStart;
          res_channel = 6'(first_channel_q) + 6'(play_ch);
          res_sample  = smp_q;
          res_volume  = vol_q;
          res_rate    = rate_q;
          res_panning = pan_q;
        end
      end
      svalloc_pkg::OpStop: begin
        if (stop_hit) begin
          res_action  = svalloc_pkg::ActStop;
          res_channel = 6'(first_channel_q) + 6'(stop_ch);
        end else begin
          res_status = 1'b1;
        end
      end
      svalloc_pkg::OpStopAll: begin
        res_action  = svalloc_pkg::ActStop;
        res_channel = 6'(first_channel_q) + 6'(idx_q);
        res_last    = idx_last;
      end
      default: res_status = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_channel_q <= '0;
      channel_count_q <= 4'd8;
      sample_count_q  <= '0;
      chan_valid_q    <= '0;
      last_used_q     <= '0;
      id_counter_q    <= '0;
      idx_q           <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          svalloc_pkg::CfgFirstChannel: first_channel_q <= cfg_data_i;
          svalloc_pkg::CfgChannelCount: channel_count_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (cmd_i.accept) begin
        idx_q <= '0;
      end
      if (cmd_i.fire) begin
        if (op_q == svalloc_pkg::OpRegister && !full) begin
          sample_count_q <= sample_count_q + 1'b1;
        end
        if (do_play) begin
          last_used_q           <= play_ch;
          id_counter_q          <= id_next;
          chan_valid_q[play_ch] <= 1'b1;
        end
        if (op_q == svalloc_pkg::OpStopAll) begin
          idx_q <= idx_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= operation_i;
      smp_q  <= sample_index_i;
      vol_q  <= volume_i;
      rate_q <= rate_i;
      pan_q  <= panning_i;
      pid_q  <= play_id_i;
      mask_q <= playing_mask_i;
    end
    if (cmd_i.fire) begin
      status_bit_o   <= res_status;
      result_value_o <= res_value;
      action_o       <= res_action;
      channel_o      <= res_channel;
      out_sample_o   <= res_sample;
      out_volume_o   <= res_volume;
      out_rate_o     <= res_rate;
      out_panning_o  <= res_panning;
      last_o         <= res_last;
      if (do_play) begin
        chan_sample_q[play_ch] <= smp_q;
        chan_id_q[play_ch]     <= id_next[IdKeepW-1:0];
      end
    end
  end

endmodule

### rtl/sound_voice_allocator.sv
`timescale 1ns / 1ps
// Sequence: a request is accepted in idle; its result is generated once the
// output register is free and is registered there. No new request is taken
// until its last result is generated. A stop-all request gives one stop result
// per window channel, one per cycle while the output is not stalled.
// Reset: asynchronous; clears the counters, channel valid bits and configuration
// registers (first channel 0, channel count 8) at once, with no clearing pass.
module sound_voice_allocator #(
  parameter int unsigned MaxSamples  = svalloc_pkg::DefMaxSamples,
  parameter int unsigned MaxChannels = svalloc_pkg::DefMaxChannels,
  parameter int unsigned IdWidth     = svalloc_pkg::DefIdWidth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [4:0]        cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        operation_i,
  input  logic [5:0]        sample_index_i,
  input  logic [6:0]        volume_i,
  input  logic [16:0]       rate_i,
  input  logic signed [7:0] panning_i,
  input  logic [15:0]       play_id_i,
  input  logic [7:0]        playing_mask_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              status_o,
  output logic [15:0]       result_value_o,
  output logic [1:0]        action_o,
  output logic [5:0]        channel_o,
  output logic [5:0]        out_sample_o,
  output logic [6:0]        out_volume_o,
  output logic [16:0]       out_rate_o,
  output logic signed [7:0] out_panning_o,
  output logic              last_o
);

  svalloc_pkg::cmd_t    cmd;
  svalloc_pkg::status_t status;

  svalloc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  svalloc_datapath #(
    .MaxSamples  (MaxSamples),
    .MaxChannels (MaxChannels),
    .IdWidth     (IdWidth)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .operation_i    (operation_i),
    .sample_index_i (sample_index_i),
    .volume_i       (volume_i),
    .rate_i         (rate_i),
    .panning_i      (panning_i),
    .play_id_i      (play_id_i),
    .playing_mask_i (playing_mask_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .status_bit_o   (status_o),
    .result_value_o (result_value_o),
    .action_o       (action_o),
    .channel_o      (channel_o),
    .out_sample_o   (out_sample_o),
    .out_volume_o   (out_volume_o),
    .out_rate_o     (out_rate_o),
    .out_panning_o  (out_panning_o),
    .last_o         (last_o)
  );

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sound_voice_allocator: a directed table, then random requests
// under several effect windows, checked against a behavioral voice-allocation predictor.
// Depends on svalloc_pkg and the sound_voice_allocator RTL.
module tb;

  typedef struct packed {
    logic [1:0]        op;
    logic [5:0]        smp;
    logic [6:0]        vol;
    logic [16:0]       rate;
    logic signed [7:0] pan;
    logic [15:0]       pid;
    logic [7:0]        mask;
  } sfx_request_t;

  typedef struct packed {
    logic              status;
    logic [15:0]       value;
    logic [1:0]        act;
    logic [5:0]        chan;
    logic [5:0]        smp;
    logic [6:0]        vol;
    logic [16:0]       rate;
    logic signed [7:0] pan;
    logic              last;
  } voice_action_t;

  typedef struct packed {
    sfx_request_t rq;
    logic         typed;
    logic         status;
    logic [15:0]  value;
    logic [1:0]   act;
    logic [5:0]   chan;
  } plan_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic              cfg_index_i;
  logic [4:0]        cfg_data_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [1:0]        operation_i;
  logic [5:0]        sample_index_i;
  logic [6:0]        volume_i;
  logic [16:0]       rate_i;
  logic signed [7:0] panning_i;
  logic [15:0]       play_id_i;
  logic [7:0]        playing_mask_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic              status_o;
  logic [15:0]       result_value_o;
  logic [1:0]        action_o;
  logic [5:0]        channel_o;
  logic [5:0]        out_sample_o;
  logic [6:0]        out_volume_o;
  logic [16:0]       out_rate_o;
  logic signed [7:0] out_panning_o;
  logic              last_o;

  sound_voice_allocator dut (.*);

  voice_action_t voice_actions_due[$];
  int unsigned   mismatch_count = 0;
  int unsigned   burst_left = 0;

  int unsigned   samples_held;
  bit            voice_busy[8];
  logic [5:0]    voice_sample[8];
  logic [15:0]   voice_tag[8];
  int unsigned   recent_voice;
  logic [15:0]   tag_counter;
  logic [4:0]    win_base;
  logic [3:0]    win_size_reg;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("sound_voice_allocator test failed");
    $finish;
  end

  function automatic voice_action_t plain_result(logic status, logic [15:0] value);
    voice_action_t r;
    r = '0;
    r.status = status;
    r.value = value;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic int unsigned window_size();
    if (win_size_reg == 0) return 1;
    if (win_size_reg > 8) return 8;
    return 32'(win_size_reg);
  endfunction

  function automatic void predict_voice_actions(sfx_request_t rq);
    int unsigned win;
    int unsigned pick;
    voice_action_t r;
    win = window_size();
    pick = win;
    r = '0;
    case (rq.op)
      svalloc_pkg::OpRegister: begin
        if (samples_held >= 64) begin
          voice_actions_due.push_back(plain_result(1'b1, 16'd0));
        end else begin
          voice_actions_due.push_back(plain_result(1'b0, 16'(samples_held)));
          samples_held++;
        end
      end
      svalloc_pkg::OpPlay: begin
        if (rq.smp >= samples_held) begin
          voice_actions_due.push_back(plain_result(1'b1, 16'd0));
        end else begin
          for (int unsigned i = 0; i < win; i++)
            if (pick == win && !rq.mask[i]) pick = i;
          for (int unsigned i = 0; i < win; i++)
            if (pick == win && voice_busy[i] && voice_sample[i] == rq.smp) pick = i;
          if (pick == win) pick = (recent_voice + 1 >= win) ? 0 : recent_voice + 1;
          recent_voice = pick;
          tag_counter = tag_counter + 16'd1;
          voice_busy[pick] = 1'b1;
          voice_sample[pick] = rq.smp;
          voice_tag[pick] = tag_counter;
          r.value = tag_counter;
          r.act = svalloc_pkg::ActStart;
          r.chan = 6'(win_base) + 6'(pick);
          r.smp = rq.smp;
          r.vol = rq.vol;
          r.rate = rq.rate;
          r.pan = rq.pan;
          r.last = 1'b1;
          voice_actions_due.push_back(r);
        end
      end
      svalloc_pkg::OpStop: begin
        for (int unsigned i = 0; i < win; i++)
          if (pick == win && voice_busy[i] && voice_tag[i] == rq.pid) pick = i;
        if (pick == win) begin
          voice_actions_due.push_back(plain_result(1'b1, 16'd0));
        end else begin
          r.act = svalloc_pkg::ActStop;
          r.chan = 6'(win_base) + 6'(pick);
          r.last = 1'b1;
          voice_actions_due.push_back(r);
        end
      end
      default: begin
        for (int unsigned i = 0; i < win; i++) begin
          r = '0;
          r.act = svalloc_pkg::ActStop;
          r.chan = 6'(win_base) + 6'(i);
          r.last = (i + 1 == win);
          voice_actions_due.push_back(r);
        end
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin : watch_results
    voice_action_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (voice_actions_due.size() == 0) begin
        $display("%0t: result with none expected, actual action %0h channel %0h",
                 $time, action_o, channel_o);
        mismatch_count++;
      end else begin
        want = voice_actions_due.pop_front();
        check_field("status", 32'(want.status), 32'(status_o));
        check_field("result_value", 32'(want.value), 32'(result_value_o));
        check_field("action", 32'(want.act), 32'(action_o));
        check_field("channel", 32'(want.chan), 32'(channel_o));
        check_field("out_sample", 32'(want.smp), 32'(out_sample_o));
        check_field("out_volume", 32'(want.vol), 32'(out_volume_o));
        check_field("out_rate", 32'(want.rate), 32'(out_rate_o));
        check_field("out_panning", 32'(unsigned'(want.pan)), 32'(unsigned'(out_panning_o)));
        check_field("last", 32'(want.last), 32'(last_o));
      end
    end
  end

  initial begin : receiver
    int unsigned tick;
    logic [7:0]  pattern;
    tick = 0;
    pattern = '0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (tick % 32 == 0) begin
        pattern = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
        if (pattern == 8'hFF) pattern = 8'h7F;
      end
      out_stall_i <= pattern[tick % 8];
      tick++;
    end
  end

  task automatic send_request(input sfx_request_t rq);
    int unsigned idle;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (idle != 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (idle - 1) @(negedge clk_i);
      end
    end
    if (burst_left != 0) burst_left--;
    @(negedge clk_i);
    operation_i <= rq.op;
    sample_index_i <= rq.smp;
    volume_i <= rq.vol;
    rate_i <= rq.rate;
    panning_i <= rq.pan;
    play_id_i <= rq.pid;
    playing_mask_i <= rq.mask;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predict_voice_actions(rq);
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (voice_actions_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_window(input logic [4:0] base, input logic [4:0] size);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= svalloc_pkg::CfgFirstChannel;
    cfg_data_i <= base;
    @(negedge clk_i);
    cfg_index_i <= svalloc_pkg::CfgChannelCount;
    cfg_data_i <= size;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    win_base = base;
    win_size_reg = size[3:0];
  endtask

  function automatic sfx_request_t random_request(logic [1:0] op);
    sfx_request_t rq;
    int unsigned k;
    rq.op = op;
    rq.vol = 7'($urandom_range(0, 64));
    rq.rate = 17'($urandom_range(0, 17'h1FFFF));
    rq.pan = 8'($urandom);
    rq.pid = 16'($urandom);
    rq.smp = 6'($urandom_range(0, 63));
    if (samples_held > 0 && $urandom_range(0, 7) != 0)
      rq.smp = 6'($urandom_range(0, samples_held - 1));
    case ($urandom_range(0, 2))
      0: rq.mask = 8'hFF;
      1: rq.mask = 8'($urandom);
      default: rq.mask = ~(8'd1 << $urandom_range(0, 7));
    endcase
    k = $urandom_range(0, 7);
    if (voice_busy[k] && $urandom_range(0, 3) != 0) rq.pid = voice_tag[k];
    return rq;
  endfunction

  function automatic logic [1:0] random_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return svalloc_pkg::OpRegister;
    if (r < 65) return svalloc_pkg::OpPlay;
    if (r < 87) return svalloc_pkg::OpStop;
    return svalloc_pkg::OpStopAll;
  endfunction

  function automatic plan_row_t row(logic [1:0] op, logic [5:0] smp, logic [6:0] vol,
                                    logic [16:0] rate, logic signed [7:0] pan,
                                    logic [15:0] pid, logic [7:0] mask, logic typed,
                                    logic status, logic [15:0] value, logic [1:0] act,
                                    logic [5:0] chan);
    plan_row_t p;
    p.rq = '{op: op, smp: smp, vol: vol, rate: rate, pan: pan, pid: pid, mask: mask};
    p.typed = typed;
    p.status = status;
    p.value = value;
    p.act = act;
    p.chan = chan;
    return p;
  endfunction

  initial begin : stimulus
    plan_row_t     plan[19];
    voice_action_t r;
    logic [4:0]    base_list[7];
    logic [4:0]    size_list[7];

    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = svalloc_pkg::CfgFirstChannel;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    operation_i = svalloc_pkg::OpRegister;
    sample_index_i = '0;
    volume_i = '0;
    rate_i = '0;
    panning_i = '0;
    play_id_i = '0;
    playing_mask_i = '0;

    samples_held = 0;
    recent_voice = 0;
    tag_counter = '0;
    win_base = '0;
    win_size_reg = 4'd8;
    for (int i = 0; i < 8; i++) begin
      voice_busy[i] = 1'b0;
      voice_sample[i] = '0;
      voice_tag[i] = '0;
    end

    plan[0]  = row(svalloc_pkg::OpPlay, 6'd0, 7'd10, 17'd100, 8'sd0, 16'd0, 8'h00,
                   1'b1, 1'b1, 16'd0, svalloc_pkg::ActNone, 6'd0);
    plan[1]  = row(svalloc_pkg::OpStop, 6'd0, 7'd0, 17'd0, 8'sd0, 16'd0, 8'h00,
                   1'b1, 1'b1, 16'd0, svalloc_pkg::ActNone, 6'd0);
    plan[2]  = row(svalloc_pkg::OpStopAll, 6'd0, 7'd0, 17'd0, 8'sd0, 16'd0, 8'h00,
                   1'b0, 1'b0, 16'd0, svalloc_pkg::ActNone, 6'd0);
    plan[3]  = row(svalloc_pkg::OpRegister, 6'd63, 7'd64, 17'h1FFFF, -8'sd128, 16'hFFFF, 8'hFF,
                   1'b1, 1'b0, 16'd0, svalloc_pkg::ActNone, 6'd0);
    plan[4]  = row(svalloc_pkg::OpRegister, 6'd0, 7'd0, 17'd0, 8'sd0, 16'd0, 8'h00,
                   1'b1, 1'b0, 16'd1, svalloc_pkg::ActNone, 6'd0);
    plan[5]  = row(svalloc_pkg::OpRegister, 6'd0, 7'd0, 17'd0, 8'sd0, 16'd0, 8'h00,
                   1'b1, 1'b0, 16'd2, svalloc_pkg::ActNone, 6'd0);
    plan[6]  = row(svalloc_pkg::OpPlay, 6'd3, 7'd20, 17'd44100, 8'sd5, 16'd0, 8'h00,
                   1'b1, 1'b1, 16'd0, svalloc_pkg::ActNone, 6'd0);
    plan[7]  = row(svalloc_pkg::OpPlay, 6'd0, 7'd64, 17'h1FFFF, -8'sd128, 16'd0, 8'h00,
                   1'b1, 1'b0, 16'd1, svalloc_pkg::ActStart, 6'd0);
    plan[8]  = row(svalloc_pkg::OpPlay, 6'd1, 7'd0, 17'd0, 8'sd127, 16'hFFFF, 8'h01,
                   1'b1, 1'b0, 16'd2, svalloc_pkg::ActStart, 6'd1);
    plan[9]  = row(svalloc_pkg::OpPlay, 6'd2, 7'd33, 17'd22050, -8'sd1, 16'd0, 8'hFF,
                   1'b0, 1'b0, 16'd0, svalloc_pkg::ActNone, 6'd0);
    plan[10] = row(svalloc_pkg::OpPlay, 6'd0, 7'd1, 17'd1, 8'sd1, 16'd0, 8'hFF,
                   1'b0, 1'b0, 16'd0, svalloc_pkg::ActNone, 6'd0);
    plan[11] = row(svalloc_pkg::OpPlay, 6'd2, 7'd63, 17'h10000, 8'sd64, 16'd0, 8'h7F,
                   1'b0, 1'b0, 16'd0, svalloc_pkg::ActNone, 6'd0);
    plan[12] = row(svalloc_pkg::OpStop, 6'd0, 7'd0, 17'd0, 8'sd0, 16'd2, 8'h00,
                   1'b0, 1'b0, 16'd0, svalloc_pkg::ActNone, 6'd0);
    plan[13] = row(svalloc_pkg::OpStop, 6'd0, 7'd0, 17'd0, 8'sd0, 16'hFFFF, 8'h00,
                   1'b1, 1'b1, 16'd0, svalloc_pkg::ActNone, 6'd0);
    plan[14] = row(svalloc_pkg::OpPlay, 6'd1, 7'd12, 17'd8000, -8'sd64, 16'd0, 8'hFF,
                   1'b0, 1'b0, 16'd0, svalloc_pkg::ActNone, 6'd0);
    plan[15] = row(svalloc_pkg::OpPlay, 6'd2, 7'd12, 17'd8000, 8'sd0, 16'd0, 8'hFF,
                   1'b0, 1'b0, 16'd0, svalloc_pkg::ActNone, 6'd0);
    plan[16] = row(svalloc_pkg::OpRegister, 6'd0, 7'd0, 17'd0, 8'sd0, 16'd0, 8'h00,
                   1'b1, 1'b0, 16'd3, svalloc_pkg::ActNone, 6'd0);
    plan[17] = row(svalloc_pkg::OpPlay, 6'd3, 7'd50, 17'd11025, 8'sd100, 16'd0, 8'hAA,
                   1'b0, 1'b0, 16'd0, svalloc_pkg::ActNone, 6'd0);
    plan[18] = row(svalloc_pkg::OpStopAll, 6'd0, 7'd0, 17'd0, 8'sd0, 16'd0, 8'h00,
                   1'b0, 1'b0, 16'd0, svalloc_pkg::ActNone, 6'd0);

    base_list = '{5'd0, 5'd31, 5'd5, 5'd0, 5'd17, 5'd31, 5'd2};
    size_list = '{5'd8, 5'd1, 5'd3, 5'd0, 5'd15, 5'd8, 5'd17};

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < 19; i++) begin
      send_request(plan[i].rq);
      if (plan[i].typed) begin
        r = voice_actions_due.pop_back();
        r.status = plan[i].status;
        r.value = plan[i].value;
        r.act = plan[i].act;
        r.chan = plan[i].chan;
        voice_actions_due.push_back(r);
      end
    end

    for (int p = 0; p < 7; p++) begin
      settle();
      set_window(base_list[p], size_list[p]);
      for (int i = 0; i < 4; i++) send_request(random_request(random_op()));
      if (p == 1) begin
        while (samples_held < 64) send_request(random_request(svalloc_pkg::OpRegister));
        repeat (2) send_request(random_request(svalloc_pkg::OpRegister));
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("sound_voice_allocator test passed");
    end else begin
      $display("sound_voice_allocator test failed");
    end
    $finish;
  end

endmodule
